// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;

  typedef enum logic [1:0] {
    MODE_PUSH_AHEAD = 2'd0,
    MODE_PUSH_AFTER = 2'd1,
    MODE_POP        = 2'd2,
    MODE_POP_ALT    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_POPPED    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic                     after_eq;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] priority_key;
  } cmd_t;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue built as a row of compare-and-shift cells.
// Each request is applied to the whole row in the cycle it is accepted.
// The result appears in the output register in the cycle after acceptance.
// Throughput is one request per cycle; input stalls only while a result waits.
// Synchronous active-low reset empties the queue and clears the output valid.
module sorted_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic signed [spq_pkg::DATA_W-1:0] in_value,
  input  logic signed [spq_pkg::DATA_W-1:0] in_priority_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [spq_pkg::DATA_W-1:0] out_value,
  output logic signed [spq_pkg::DATA_W-1:0] out_priority,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy
);

  logic                              accept;
  logic                              is_pop;
  logic                              full;
  logic                              empty;
  spq_pkg::cmd_t                     cmd;
  logic [spq_pkg::CNT_W-1:0]         count_r;
  logic [spq_pkg::CNT_W-1:0]         count_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  spq_pkg::status_t                  status_r;
  spq_pkg::status_t                  status_nxt;
  logic signed [spq_pkg::DATA_W-1:0] out_value_r;
  logic signed [spq_pkg::DATA_W-1:0] out_value_nxt;
  logic signed [spq_pkg::DATA_W-1:0] out_priority_r;
  logic signed [spq_pkg::DATA_W-1:0] out_priority_nxt;

  logic                              go       [spq_pkg::CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] cell_val [spq_pkg::CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] cell_pri [spq_pkg::CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_pop   = in_mode[1];
  assign full     = (count_r == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign empty    = (count_r == '0);

  always_comb begin
    cmd.push         = accept && !is_pop && !full;
    cmd.pop          = accept && is_pop && !empty;
    cmd.after_eq     = (in_mode == spq_pkg::MODE_PUSH_AFTER);
    cmd.value        = in_value;
    cmd.priority_key = in_priority_req;
  end

  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    logic                              l_go;
    logic signed [spq_pkg::DATA_W-1:0] l_val;
    logic signed [spq_pkg::DATA_W-1:0] l_pri;
    logic signed [spq_pkg::DATA_W-1:0] r_val;
    logic signed [spq_pkg::DATA_W-1:0] r_pri;

    if (i == 0) begin : g_head
      assign l_go  = 1'b1;
      assign l_val = '0;
      assign l_pri = '0;
    end else begin : g_body
      assign l_go  = go[i-1];
      assign l_val = cell_val[i-1];
      assign l_pri = cell_pri[i-1];
    end

    if (i == spq_pkg::CAPACITY - 1) begin : g_tail
      assign r_val = '0;
      assign r_pri = '0;
    end else begin : g_inner
      assign r_val = cell_val[i+1];
      assign r_pri = cell_pri[i+1];
    end

    spq_cell u_cell (
      .clk            (clk),
      .cmd            (cmd),
      .occupied       (count_r > spq_pkg::CNT_W'(i)),
      .left_go        (l_go),
      .left_value     (l_val),
      .left_priority  (l_pri),
      .right_value    (r_val),
      .right_priority (r_pri),
      .go             (go[i]),
      .value          (cell_val[i]),
      .priority_val   (cell_pri[i])
    );
  end

  always_comb begin
    count_nxt        = count_r;
    out_valid_nxt    = out_valid_r && out_stall;
    status_nxt       = status_r;
    out_value_nxt    = out_value_r;
    out_priority_nxt = out_priority_r;
    if (accept) begin
      out_valid_nxt    = 1'b1;
      out_value_nxt    = '0;
      out_priority_nxt = '0;
      priority if (is_pop && empty) begin
        status_nxt = spq_pkg::ST_POP_EMPTY;
      end else if (is_pop) begin
        status_nxt       = spq_pkg::ST_POPPED;
        out_value_nxt    = cell_val[0];
        out_priority_nxt = cell_pri[0];
        count_nxt        = count_r - spq_pkg::CNT_W'(1);
      end else if (full) begin
        status_nxt = spq_pkg::ST_PUSH_FULL;
      end else begin
        status_nxt = spq_pkg::ST_INSERTED;
        count_nxt  = count_r + spq_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r       <= status_nxt;
    out_value_r    <= out_value_nxt;
    out_priority_r <= out_priority_nxt;
  end

  logic [spq_pkg::OCC_W-1:0] occ_r;
  logic [spq_pkg::OCC_W-1:0] occ_nxt;

  assign occ_nxt = accept ? spq_pkg::OCC_W'(count_nxt) : occ_r;

  always_ff @(posedge clk) begin
    occ_r <= occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_value     = out_value_r;
  assign out_priority  = out_priority_r;
  assign out_occupancy = occ_r;

endmodule

// ===== hw/rtl/spq_cell.sv =====
module spq_cell (
  input  logic                              clk,
  input  spq_pkg::cmd_t                     cmd,
  input  logic                              occupied,
  input  logic                              left_go,
  input  logic signed [spq_pkg::DATA_W-1:0] left_value,
  input  logic signed [spq_pkg::DATA_W-1:0] left_priority,
  input  logic signed [spq_pkg::DATA_W-1:0] right_value,
  input  logic signed [spq_pkg::DATA_W-1:0] right_priority,
  output logic                              go,
  output logic signed [spq_pkg::DATA_W-1:0] value,
  output logic signed [spq_pkg::DATA_W-1:0] priority_val
);

  logic signed [spq_pkg::DATA_W-1:0] value_r;
  logic signed [spq_pkg::DATA_W-1:0] value_nxt;
  logic signed [spq_pkg::DATA_W-1:0] priority_r;
  logic signed [spq_pkg::DATA_W-1:0] priority_nxt;

  // An occupied entry stays in place when the new request belongs behind it.
  assign go = occupied && (cmd.after_eq ? (priority_r <= cmd.priority_key)
                                        : (priority_r < cmd.priority_key));

  always_comb begin
    value_nxt    = value_r;
    priority_nxt = priority_r;
    priority if (cmd.pop) begin
      value_nxt    = right_value;
      priority_nxt = right_priority;
    end else if (cmd.push && !go) begin
      if (left_go) begin
        value_nxt    = cmd.value;
        priority_nxt = cmd.priority_key;
      end else begin
        value_nxt    = left_value;
        priority_nxt = left_priority;
      end
    end else begin
      value_nxt    = value_r;
      priority_nxt = priority_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    priority_r <= priority_nxt;
  end

  assign value        = value_r;
  assign priority_val = priority_r;

endmodule

// ===== sim/tb_sorted_priority_queue.sv =====
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD_CYCLES = 60;
  localparam int MAX_PRINTED      = 20;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURSTY
  } stall_style_t;

  typedef struct {
    spq_pkg::status_t                  status;
    logic signed [spq_pkg::DATA_W-1:0] value;
    logic signed [spq_pkg::DATA_W-1:0] prio;
    logic [spq_pkg::OCC_W-1:0]         occupancy;
  } queue_result_t;

  logic                              clk             = 1'b0;
  logic                              rst_n           = 1'b0;
  logic                              in_valid        = 1'b0;
  logic                              in_stall;
  logic [1:0]                        in_mode         = spq_pkg::MODE_POP;
  logic signed [spq_pkg::DATA_W-1:0] in_value        = '0;
  logic signed [spq_pkg::DATA_W-1:0] in_priority_req = '0;
  logic                              out_valid;
  logic                              out_stall       = 1'b0;
  logic [1:0]                        out_status;
  logic signed [spq_pkg::DATA_W-1:0] out_value;
  logic signed [spq_pkg::DATA_W-1:0] out_priority;
  logic [spq_pkg::OCC_W-1:0]         out_occupancy;

  logic signed [spq_pkg::DATA_W-1:0] queue_values [spq_pkg::CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] queue_prios [spq_pkg::CAPACITY];
  int                                queue_count = 0;

  queue_result_t            pending_results [$];
  int                       mismatch_count  = 0;
  int                       status_seen [4] = '{0, 0, 0, 0};
  int                       burst_left      = 0;

  stall_style_t             stall_style     = STALL_NONE;
  int                       stall_phase     = 0;
  int                       hold_requested  = 0;
  int                       hold_served     = 0;
  int                       hold_left       = 0;

  sorted_priority_queue u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy)
  );

  always #10 clk = ~clk;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Applies one request to the expected queue contents and returns its result.
  function automatic queue_result_t apply_queue_request(
    logic [1:0] mode,
    logic signed [spq_pkg::DATA_W-1:0] value,
    logic signed [spq_pkg::DATA_W-1:0] prio);
    queue_result_t res;
    int            pos;
    int            i;
    res.status = spq_pkg::ST_INSERTED;
    res.value  = '0;
    res.prio   = '0;
    if (mode[1]) begin
      if (queue_count == 0) begin
        res.status = spq_pkg::ST_POP_EMPTY;
      end else begin
        res.status = spq_pkg::ST_POPPED;
        res.value  = queue_values[0];
        res.prio   = queue_prios[0];
        for (i = 1; i < queue_count; i++) begin
          queue_values[i-1] = queue_values[i];
          queue_prios[i-1]  = queue_prios[i];
        end
        queue_count--;
      end
    end else if (queue_count >= spq_pkg::CAPACITY) begin
      res.status = spq_pkg::ST_PUSH_FULL;
    end else begin
      pos = 0;
      while (pos < queue_count &&
             ((mode == spq_pkg::MODE_PUSH_AHEAD) ? (queue_prios[pos] < prio)
                                                 : (queue_prios[pos] <= prio))) begin
        pos++;
      end
      for (i = queue_count; i > pos; i--) begin
        queue_values[i] = queue_values[i-1];
        queue_prios[i]  = queue_prios[i-1];
      end
      queue_values[pos] = value;
      queue_prios[pos]  = prio;
      queue_count++;
    end
    res.occupancy = spq_pkg::OCC_W'(queue_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic send_request(input logic [1:0] mode,
                              input logic signed [spq_pkg::DATA_W-1:0] value,
                              input logic signed [spq_pkg::DATA_W-1:0] prio);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_value        <= value;
    in_priority_req <= prio;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_queue_request(mode, value, prio));
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic signed [spq_pkg::DATA_W-1:0] pick_priority();
    if ($urandom_range(1) == 0) begin
      return $urandom;
    end
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      default: return $signed(32'($urandom_range(6))) - 32'sd3;
    endcase
  endfunction

  function automatic logic [1:0] pick_mode(input int pop_pct);
    if ($urandom_range(99) < pop_pct) begin
      return ($urandom_range(1) == 0) ? spq_pkg::MODE_POP : spq_pkg::MODE_POP_ALT;
    end
    return ($urandom_range(1) == 0) ? spq_pkg::MODE_PUSH_AHEAD : spq_pkg::MODE_PUSH_AFTER;
  endfunction

  // Sends in bursts of random length separated by random gaps.
  task automatic send_paced(input logic [1:0] mode);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap        = $urandom_range(0, 4);
      if (gap != 0) begin
        idle_cycles(gap);
      end
    end
    burst_left--;
    send_request(mode, $urandom, pick_priority());
  endtask

  task automatic reset_block();
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_empty_pop();
    send_request(spq_pkg::MODE_POP, 32'sh7fff_ffff, 32'sh8000_0000);
    send_request(spq_pkg::MODE_POP_ALT, 32'sh8000_0000, 32'sh7fff_ffff);
    wait_for_drain();
  endtask

  // Equal priorities must leave in reverse order for pushes ahead and in
  // arrival order for pushes after, with both priority extremes in play.
  task automatic test_tie_order();
    int i;
    send_request(spq_pkg::MODE_PUSH_AHEAD, 32'sh1111_1111, 32'sd5);
    send_request(spq_pkg::MODE_PUSH_AHEAD, 32'sh2222_2222, 32'sd5);
    send_request(spq_pkg::MODE_PUSH_AFTER, 32'sh3333_3333, 32'sd5);
    send_request(spq_pkg::MODE_PUSH_AHEAD, 32'sh7fff_ffff, 32'sh8000_0000);
    send_request(spq_pkg::MODE_PUSH_AFTER, 32'sh8000_0000, 32'sh7fff_ffff);
    send_request(spq_pkg::MODE_PUSH_AHEAD, 32'sh0000_0000, -32'sd1);
    for (i = 0; i < 6; i++) begin
      send_request((i % 2 == 0) ? spq_pkg::MODE_POP : spq_pkg::MODE_POP_ALT,
                   $urandom, $urandom);
    end
    wait_for_drain();
  endtask

  task automatic test_random_mix();
    int chunk;
    int i;
    int pop_pct;
    for (chunk = 0; chunk < 6; chunk++) begin
      stall_style <= stall_style_t'($urandom_range(2));
      pop_pct = 30 + 20 * $urandom_range(2);
      for (i = 0; i < 35; i++) begin
        send_paced(pick_mode(pop_pct));
      end
    end
    wait_for_drain();
  endtask

  // Overfills the queue so pushes are dropped, then drains past empty.
  task automatic test_fill_and_drain();
    int round;
    int i;
    int pushes;
    int pops;
    for (round = 0; round < 3; round++) begin
      stall_style <= stall_style_t'($urandom_range(2));
      pushes = spq_pkg::CAPACITY + $urandom_range(1, 4);
      pops   = pushes + $urandom_range(1, 3);
      for (i = 0; i < pushes; i++) begin
        send_paced(pick_mode(0));
      end
      for (i = 0; i < pops; i++) begin
        send_paced(pick_mode(100));
      end
    end
    wait_for_drain();
  endtask

  task automatic test_back_pressure();
    int i;
    stall_style    <= STALL_NONE;
    hold_requested <= hold_requested + 1;
    for (i = 0; i < 30; i++) begin
      send_request(pick_mode(40), $urandom, pick_priority());
    end
    wait_for_drain();
  endtask

  task automatic test_full_rate();
    int i;
    stall_style <= STALL_NONE;
    for (i = 0; i < 80; i++) begin
      send_request(pick_mode(45), $urandom, pick_priority());
    end
    wait_for_drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served < hold_requested) begin
      out_stall   <= 1'b1;
      hold_left   <= LONG_HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      stall_phase <= (stall_phase + 1) % 7;
      case (stall_style)
        STALL_RANDOM: out_stall <= ($urandom_range(2) == 0);
        STALL_BURSTY: out_stall <= (stall_phase >= 4);
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    queue_result_t expected;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        expected = pending_results.pop_front();
        status_seen[expected.status]++;
        if (out_status !== expected.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", out_status, expected.status));
        end
        if (out_value !== expected.value) begin
          report_mismatch($sformatf("value %h, expected %h", out_value, expected.value));
        end
        if (out_priority !== expected.prio) begin
          report_mismatch($sformatf("priority %h, expected %h", out_priority, expected.prio));
        end
        if (out_occupancy !== expected.occupancy) begin
          report_mismatch($sformatf("occupancy %0d, expected %0d", out_occupancy,
                                    expected.occupancy));
        end
      end
    end
  end

  initial begin
    reset_block();
    test_empty_pop();
    test_tie_order();
    test_random_mix();
    test_fill_and_drain();
    test_back_pressure();
    test_full_rate();
    $display("Checked %0d inserts, %0d pops, %0d pops on empty and %0d dropped pushes,",
             status_seen[spq_pkg::ST_INSERTED], status_seen[spq_pkg::ST_POPPED],
             status_seen[spq_pkg::ST_POP_EMPTY], status_seen[spq_pkg::ST_PUSH_FULL]);
    $display("including priority ties, both pop codes and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
